>>> hw/rtl/lbg_pkg.sv
// Shared types and constants for the LED breathing brightness generator.
// No dependencies; lbg_dp, lbg_ctrl and the top refer to it by scoped names.
`timescale 1ns / 1ps

package lbg_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] CFG_MODE   = 3'd0;
    localparam logic [2:0] CFG_LOW    = 3'd1;
    localparam logic [2:0] CFG_HIGH   = 3'd2;
    localparam logic [2:0] CFG_PERIOD = 3'd3;
    localparam logic [2:0] CFG_COLOR  = 3'd4;

    // Mode codes
    localparam logic [1:0] MODE_OFF     = 2'd0;
    localparam logic [1:0] MODE_SOLID   = 2'd1;
    localparam logic [1:0] MODE_BREATHE = 2'd2;

    localparam logic [6:0]  PCT_MAX  = 7'd100;
    localparam logic [10:0] Q_ONE    = 11'd1024;
    localparam logic [10:0] Q_HALF   = 11'd512;
    // floor(x / 100) == (x * 5243) >> 19 for every x below 43690
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    // Channel select for the scaling steps
    localparam logic [1:0] CH_GREEN = 2'd0;
    localparam logic [1:0] CH_RED   = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MOD   = 9'b000000010,
        S_QST   = 9'b000000100,
        S_QDIV  = 9'b000001000,
        S_SQ    = 9'b000010000,
        S_LVL   = 9'b000100000,
        S_PROD  = 9'b001000000,
        S_RECIP = 9'b010000000,
        S_LOAD  = 9'b100000000
    } t_state;

    typedef struct packed {
        logic       start_mod;
        logic       cap_phase;
        logic       start_q;
        logic       do_sq;
        logic       lvl_breathe;
        logic       lvl_simple;
        logic       prod;
        logic       recip;
        logic [1:0] ch_sel;
        logic       load_out;
    } t_cmd;

    typedef struct packed {
        logic breathe;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

>>> hw/rtl/lbg_div.sv
// Restoring divider, one quotient bit per cycle: 32-bit dividend, 16-bit divisor.
// Depends on nothing; instantiated by lbg_dp.
`timescale 1ns / 1ps

module lbg_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient,
    output logic [15:0] o_remainder
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [4:0]  r_cnt, n_cnt;
    logic [31:0] r_quo, n_quo;
    logic [15:0] r_rem, n_rem;
    logic [15:0] r_dsr, n_dsr;
    logic [16:0] rem_sh;
    logic        ge;

    assign rem_sh = {r_rem, r_quo[31]};
    assign ge     = rem_sh >= {1'b0, r_dsr};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 5'd31;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            // shift one dividend bit in, subtract when it fits
            n_rem = ge ? 16'(rem_sh - {1'b0, r_dsr}) : rem_sh[15:0];
            n_quo = {r_quo[30:0], ge};
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

>>> hw/rtl/lbg_dp.sv
// Datapath: configuration registers, elapsed time, easing math, channel scaling
// and the output register. Depends on lbg_pkg and lbg_div.
`timescale 1ns / 1ps

module lbg_dp #(
    parameter int STEP_MS = 80
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [23:0]      i_cfg_data,
    input  lbg_pkg::t_cmd    i_cmd,
    output lbg_pkg::t_status o_status,
    output logic             o_m_valid,
    input  logic             i_m_ready,
    output logic [31:0]      o_m_data
);

    logic [1:0]  r_mode;
    logic [6:0]  r_low, r_high;
    logic [15:0] r_period;
    logic [23:0] r_color;
    logic [31:0] r_elapsed;
    logic [15:0] r_phase;
    logic [20:0] r_sq;
    logic        r_qlow;
    logic [6:0]  r_level;
    logic [14:0] r_prod;
    logic [7:0]  r_chan [3];
    logic        r_out_valid;
    logic [31:0] r_out_data;

    logic [6:0]  cfg_pct, lo, hi;
    logic [14:0] half;
    logic [15:0] tri_val;
    logic        div_start, div_done;
    logic [31:0] div_dividend, div_quo;
    logic [15:0] div_divisor, div_rem;
    logic [10:0] qc, qa, ease;
    logic [17:0] span_prod;
    logic [7:0]  ch_byte;
    logic [27:0] recip_prod;
    logic [6:0]  simple_level;

    assign cfg_pct = (i_cfg_data[6:0] > lbg_pkg::PCT_MAX) ? lbg_pkg::PCT_MAX : i_cfg_data[6:0];
    assign lo      = (r_low < r_high) ? r_low : r_high;
    assign hi      = (r_low < r_high) ? r_high : r_low;
    assign half    = r_period[15:1];
    assign tri_val = (r_phase <= {1'b0, half}) ? r_phase : r_period - r_phase;

    // mod pass: elapsed % period; q pass: tri * 1024 / half
    assign div_start    = i_cmd.start_mod | i_cmd.start_q;
    assign div_dividend = i_cmd.start_mod ? r_elapsed : {6'd0, tri_val, 10'd0};
    assign div_divisor  = i_cmd.start_mod ? r_period : {1'b0, half};

    lbg_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    assign qc   = (div_quo > {21'd0, lbg_pkg::Q_ONE}) ? lbg_pkg::Q_ONE : div_quo[10:0];
    assign qa   = (qc < lbg_pkg::Q_HALF) ? qc : lbg_pkg::Q_ONE - qc;
    assign ease = r_qlow ? r_sq[19:9] : lbg_pkg::Q_ONE - r_sq[19:9];
    assign span_prod = 18'(hi - lo) * 18'(ease);

    always_comb begin
        case (r_mode)
            lbg_pkg::MODE_SOLID:   simple_level = hi;
            lbg_pkg::MODE_BREATHE: simple_level = (r_period == 16'd1) ? lo : 7'd0;
            default:               simple_level = 7'd0;
        endcase
    end

    always_comb begin
        case (i_cmd.ch_sel)
            lbg_pkg::CH_GREEN: ch_byte = r_color[15:8];
            lbg_pkg::CH_RED:   ch_byte = r_color[23:16];
            default:           ch_byte = r_color[7:0];
        endcase
    end

    assign recip_prod = 28'(r_prod) * 28'(lbg_pkg::RECIP_100);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= lbg_pkg::MODE_OFF;
            r_low       <= '0;
            r_high      <= '0;
            r_period    <= '0;
            r_color     <= '0;
            r_elapsed   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lbg_pkg::CFG_MODE:   r_mode   <= i_cfg_data[1:0];
                    lbg_pkg::CFG_LOW:    r_low    <= cfg_pct;
                    lbg_pkg::CFG_HIGH:   r_high   <= cfg_pct;
                    lbg_pkg::CFG_PERIOD: r_period <= i_cfg_data[15:0];
                    lbg_pkg::CFG_COLOR:  r_color  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
                r_elapsed   <= r_elapsed + 32'(STEP_MS);
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_phase)   r_phase <= div_rem;
        if (i_cmd.do_sq) begin
            r_sq   <= 21'(qa) * 21'(qa);
            r_qlow <= qc < lbg_pkg::Q_HALF;
        end
        if (i_cmd.lvl_simple)  r_level <= simple_level;
        if (i_cmd.lvl_breathe) r_level <= lo + span_prod[16:10];
        if (i_cmd.prod)        r_prod  <= 15'(ch_byte) * 15'(r_level);
        if (i_cmd.recip)       r_chan[i_cmd.ch_sel] <= recip_prod[lbg_pkg::RECIP_SHIFT +: 8];
        if (i_cmd.load_out)    r_out_data <= {1'b0, r_level, r_chan[2], r_chan[1], r_chan[0]};
    end

    assign o_status.breathe  = (r_mode == lbg_pkg::MODE_BREATHE) && (r_period > 16'd1);
    assign o_status.div_done = div_done;
    assign o_status.out_free = !r_out_valid || i_m_ready;
    assign o_m_valid = r_out_valid;
    assign o_m_data  = r_out_data;

endmodule

>>> hw/rtl/lbg_ctrl.sv
// Controller: sequences one refresh through the datapath steps.
// Depends on lbg_pkg.
`timescale 1ns / 1ps

module lbg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_valid,
    input  logic             i_tick,
    output logic             o_s_ready,
    output lbg_pkg::t_cmd    o_cmd,
    input  lbg_pkg::t_status i_status
);

    lbg_pkg::t_state r_state, n_state;
    logic [1:0]      r_ch, n_ch;

    always_comb begin
        n_state = r_state;
        n_ch    = r_ch;
        o_cmd   = '0;
        o_cmd.ch_sel = r_ch;
        o_s_ready = 1'b0;
        case (r_state)
            lbg_pkg::S_IDLE: begin
                o_s_ready = 1'b1;
                n_ch = lbg_pkg::CH_GREEN;
                if (i_s_valid && i_tick) begin
                    if (i_status.breathe) begin
                        o_cmd.start_mod = 1'b1;
                        n_state = lbg_pkg::S_MOD;
                    end else begin
                        o_cmd.lvl_simple = 1'b1;
                        n_state = lbg_pkg::S_PROD;
                    end
                end
            end
            lbg_pkg::S_MOD: begin
                if (i_status.div_done) begin
                    o_cmd.cap_phase = 1'b1;
                    n_state = lbg_pkg::S_QST;
                end
            end
            lbg_pkg::S_QST: begin
                o_cmd.start_q = 1'b1;
                n_state = lbg_pkg::S_QDIV;
            end
            lbg_pkg::S_QDIV: begin
                if (i_status.div_done) n_state = lbg_pkg::S_SQ;
            end
            lbg_pkg::S_SQ: begin
                o_cmd.do_sq = 1'b1;
                n_state = lbg_pkg::S_LVL;
            end
            lbg_pkg::S_LVL: begin
                o_cmd.lvl_breathe = 1'b1;
                n_state = lbg_pkg::S_PROD;
            end
            lbg_pkg::S_PROD: begin
                o_cmd.prod = 1'b1;
                n_state = lbg_pkg::S_RECIP;
            end
            lbg_pkg::S_RECIP: begin
                o_cmd.recip = 1'b1;
                if (r_ch == lbg_pkg::CH_BLUE) begin
                    n_state = lbg_pkg::S_LOAD;
                end else begin
                    n_ch = r_ch + 2'd1;
                    n_state = lbg_pkg::S_PROD;
                end
            end
            lbg_pkg::S_LOAD: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = lbg_pkg::S_IDLE;
                end
            end
            default: n_state = lbg_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lbg_pkg::S_IDLE;
            r_ch    <= lbg_pkg::CH_GREEN;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
        end
    end

endmodule

>>> hw/rtl/led_breathing_brightness_generator_unit.sv
// Top level of the LED breathing brightness generator.
// Depends on lbg_pkg, lbg_ctrl, lbg_dp (which holds lbg_div).
`timescale 1ns / 1ps

// Usage:
//   Slave stream carries refresh ticks: tdata[0] = tick. An item with tick low
//   is taken and dropped without a result. Each item with tick high yields one
//   master item: tdata[7:0] green, [15:8] red, [23:16] blue, [30:24] level %.
//   Write the configuration port (mode, low_level, high_level, period_ms,
//   color at indexes 0..4) only while no refresh is in progress.
//   From accepted tick to master tvalid, off / solid modes and breathing
//   with period below 2 run level, scale and reciprocal steps, then load;
//   breathing first runs two 32-step passes of the shared bit-serial
//   divider (elapsed % period, then tri * 1024 / half).
//   Ticks are accepted only in idle, not while a refresh is under way.
//   The result sits in an output register, so a new tick is taken while the
//   previous result waits; if the receiver still stalls when the next result
//   is done, the controller holds it and stops accepting ticks.
//   Elapsed time advances by STEP_MS when a result enters the output register.
//   Synchronous reset clears mode (to off), levels, period, color, elapsed
//   time and controller state, and empties the output register.

module led_breathing_brightness_generator_unit #(
    parameter int STEP_MS = 80
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tick stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [0] tick, [7:1] zero
    // color stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [7:0] green, [15:8] red, [23:16] blue,
                                          // [30:24] level, [31] zero
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data
);

    lbg_pkg::t_cmd    cmd;
    lbg_pkg::t_status status;

    // Sequence the refresh steps
    lbg_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_tick    (i_s_axis_tdata[0]),
        .o_s_ready (o_s_axis_tready),
        .o_cmd     (cmd),
        .i_status  (status)
    );

    // Hold config and state, do the arithmetic, drive the result stream
    lbg_dp #(
        .STEP_MS (STEP_MS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_m_valid  (o_m_axis_tvalid),
        .i_m_ready  (i_m_axis_tready),
        .o_m_data   (o_m_axis_tdata)
    );

endmodule

>>> verif/led_breathing_brightness_generator_unit_tb.sv
// Self-checking testbench for led_breathing_brightness_generator_unit.
// Depends on lbg_pkg and the RTL top; drives ticks and register writes and
// checks every color item against a predictor of the breathing math.
`timescale 1ns / 1ps

module led_breathing_brightness_generator_unit_tb;

    localparam int STEP_MS      = 80;
    localparam int DRAIN_CYCLES = 100;      // extra wait in settle()
    localparam int RANDOM_ITEMS = 1800;     // tick items in the random part
    localparam int LIMIT_NS     = 5_000_000;

    // mode code the block must treat as off
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // one color item, packed as it sits in o_m_axis_tdata[30:0]
    typedef struct packed {
        logic [6:0] level;
        logic [7:0] blue;
        logic [7:0] red;
        logic [7:0] green;
    } t_color_item;

    // a fixed expectation for one item, when the table types one in
    typedef struct {
        bit          on;
        t_color_item res;
    } t_pin;

    typedef enum bit {ROW_CFG, ROW_TICK} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [2:0]  idx;
        logic [23:0] data;
        bit          tick;
        t_pin        pin;
    } t_plan_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = 8'd0;     // [0] tick, [7:1] zero
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;            // [7:0] green, [15:8] red, [23:16] blue,
                                            // [30:24] level, [31] zero
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = 3'd0;
    logic [23:0] i_cfg_data = 24'd0;

    // register shadow and the elapsed-time counter of the predictor
    logic [1:0]  mode_r = lbg_pkg::MODE_OFF;
    logic [6:0]  low_r = 7'd0;
    logic [6:0]  high_r = 7'd0;
    logic [15:0] period_r = 16'd0;
    logic [23:0] color_r = 24'd0;
    logic [31:0] elapsed_ms = 32'd0;

    t_color_item pending_colors[$];         // color items still owed by the block
    t_pin        pin_q[$];                  // one entry per tick item offered
    t_plan_row   plan[$];
    int          fault_count = 0;
    int          send_idle_pct = 18;
    int          recv_idle_pct = 75;

    led_breathing_brightness_generator_unit #(
        .STEP_MS(STEP_MS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #(LIMIT_NS);
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Triangle wave over the period, quadratic ease in and out in 1/1024
    // units, mapped between floor and ceiling.
    function automatic logic [6:0] breathe_pct(logic [6:0] floor_pct, logic [6:0] ceil_pct);
        logic [31:0] per, half, phase, tri_ms, q, e, spread;
        per = {16'd0, period_r};
        if (per == 32'd0)
            return 7'd0;
        half = per / 32'd2;
        // a one-millisecond period has no half period: hold the floor
        if (half == 32'd0)
            return floor_pct;
        phase  = elapsed_ms % per;
        tri_ms = (phase <= half) ? phase : per - phase;
        q      = tri_ms * lbg_pkg::Q_ONE / half;
        if (q > lbg_pkg::Q_ONE)
            q = lbg_pkg::Q_ONE;
        if (q < lbg_pkg::Q_HALF)
            e = 32'd2 * q * q / lbg_pkg::Q_ONE;
        else
            e = lbg_pkg::Q_ONE
                - 32'd2 * (lbg_pkg::Q_ONE - q) * (lbg_pkg::Q_ONE - q) / lbg_pkg::Q_ONE;
        spread = ceil_pct - floor_pct;
        return floor_pct + 7'(spread * e / lbg_pkg::Q_ONE);
    endfunction

    function automatic logic [7:0] scale_channel(logic [7:0] ch, logic [6:0] pct);
        logic [31:0] prod;
        prod = ch * pct;
        return 8'(prod / lbg_pkg::PCT_MAX);
    endfunction

    // Color item for the current settings and elapsed time.
    function automatic t_color_item refresh_color();
        logic [6:0]  floor_pct, ceil_pct, pct;
        t_color_item r;
        floor_pct = (low_r < high_r) ? low_r : high_r;
        ceil_pct  = (low_r < high_r) ? high_r : low_r;
        case (mode_r)
            lbg_pkg::MODE_SOLID:   pct = ceil_pct;
            lbg_pkg::MODE_BREATHE: pct = breathe_pct(floor_pct, ceil_pct);
            default:               pct = 7'd0;     // off and the unused code
        endcase
        r.green = scale_channel(color_r[15:8], pct);
        r.red   = scale_channel(color_r[23:16], pct);
        r.blue  = scale_channel(color_r[7:0], pct);
        r.level = pct;
        return r;
    endfunction

    function automatic logic [6:0] clamp_pct(logic [23:0] data);
        return (data[6:0] > lbg_pkg::PCT_MAX) ? lbg_pkg::PCT_MAX : data[6:0];
    endfunction

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted tick, check every accepted color
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_pin        pin;
        t_color_item want, got;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                pin = '{on: 1'b0, res: '0};
                if (pin_q.size() != 0)
                    pin = pin_q.pop_front();
                // tick low: taken and dropped, state unchanged
                if (i_s_axis_tdata[0]) begin
                    pending_colors.push_back(pin.on ? pin.res : refresh_color());
                    elapsed_ms <= elapsed_ms + STEP_MS;
                end
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = o_m_axis_tdata[30:0];
                if (pending_colors.size() == 0) begin
                    $error("color item with none expected: tdata %h", o_m_axis_tdata);
                    fault_count++;
                end else begin
                    want = pending_colors.pop_front();
                    if (got.green !== want.green) begin
                        $error("green: expected %0d, actual %0d", want.green, got.green);
                        fault_count++;
                    end
                    if (got.red !== want.red) begin
                        $error("red: expected %0d, actual %0d", want.red, got.red);
                        fault_count++;
                    end
                    if (got.blue !== want.blue) begin
                        $error("blue: expected %0d, actual %0d", want.blue, got.blue);
                        fault_count++;
                    end
                    if (got.level !== want.level) begin
                        $error("level: expected %0d, actual %0d", want.level, got.level);
                        fault_count++;
                    end
                end
            end
        end
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one tick item and hold it until taken. tvalid stays high across
    // back-to-back items; it only drops on a sender gap or in settle().
    task automatic send_tick(bit tick, t_pin pin);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        pin_q.push_back(pin);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {7'd0, tick};
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // Drop the stream, wait for every owed item, then let a dropped tick
    // finish before touching the registers.
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_colors.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [23:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            lbg_pkg::CFG_MODE:   mode_r   = data[1:0];
            lbg_pkg::CFG_LOW:    low_r    = clamp_pct(data);
            lbg_pkg::CFG_HIGH:   high_r   = clamp_pct(data);
            lbg_pkg::CFG_PERIOD: period_r = data[15:0];
            lbg_pkg::CFG_COLOR:  color_r  = data;
            default:             ;         // indexes past the list are ignored
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------

    function automatic void add_cfg(logic [2:0] idx, logic [23:0] data);
        plan.push_back('{kind: ROW_CFG, idx: idx, data: data, tick: 1'b0,
                         pin: '{on: 1'b0, res: '0}});
    endfunction

    function automatic void add_tick(bit tick);
        plan.push_back('{kind: ROW_TICK, idx: '0, data: '0, tick: tick,
                         pin: '{on: 1'b0, res: '0}});
    endfunction

    function automatic void add_pinned(logic [7:0] g, logic [7:0] r, logic [7:0] b,
                                       logic [6:0] pct);
        t_color_item c;
        c.green = g;
        c.red   = r;
        c.blue  = b;
        c.level = pct;
        plan.push_back('{kind: ROW_TICK, idx: '0, data: '0, tick: 1'b1,
                         pin: '{on: 1'b1, res: c}});
    endfunction

    function automatic void build_plan();
        add_pinned(8'd0, 8'd0, 8'd0, 7'd0);          // out of reset: off, black
        add_tick(1'b0);                              // tick low: no item
        add_cfg(lbg_pkg::CFG_COLOR, 24'hFFFFFF);
        add_cfg(lbg_pkg::CFG_HIGH, 24'd100);
        add_cfg(lbg_pkg::CFG_MODE, {22'd0, lbg_pkg::MODE_SOLID});
        add_pinned(8'd255, 8'd255, 8'd255, 7'd100);
        // levels above 100 clamp to 100, upper data bits are dropped
        add_cfg(lbg_pkg::CFG_HIGH, 24'h00007F);
        add_cfg(lbg_pkg::CFG_LOW, 24'h0001F5);
        add_cfg(lbg_pkg::CFG_COLOR, 24'hFF00FF);
        add_pinned(8'd0, 8'd255, 8'd255, 7'd100);
        add_cfg(lbg_pkg::CFG_MODE, 24'hFFFFFF);      // unused mode behaves as off
        add_pinned(8'd0, 8'd0, 8'd0, 7'd0);
        add_cfg(lbg_pkg::CFG_MODE, {22'd0, lbg_pkg::MODE_BREATHE});
        add_cfg(lbg_pkg::CFG_PERIOD, 24'd0);         // zero period gives black
        add_pinned(8'd0, 8'd0, 8'd0, 7'd0);
        add_cfg(lbg_pkg::CFG_COLOR, 24'hFFFFFF);
        add_cfg(lbg_pkg::CFG_LOW, 24'd30);
        add_cfg(lbg_pkg::CFG_HIGH, 24'd70);
        add_cfg(lbg_pkg::CFG_PERIOD, 24'd1);         // no half period: floor
        add_pinned(8'd76, 8'd76, 8'd76, 7'd30);
        add_cfg(lbg_pkg::CFG_LOW, 24'd70);           // swapped levels, same floor
        add_cfg(lbg_pkg::CFG_HIGH, 24'd30);
        add_pinned(8'd76, 8'd76, 8'd76, 7'd30);
        add_cfg(lbg_pkg::CFG_COLOR + 3'd1, 24'h000000);  // beyond the list: ignored
        add_cfg(lbg_pkg::CFG_COLOR + 3'd2, 24'hA5A5A5);
        add_cfg(lbg_pkg::CFG_COLOR + 3'd3, 24'hFFFFFF);
        add_cfg(lbg_pkg::CFG_PERIOD, 24'hAB0001);    // upper bits dropped: period one
        add_pinned(8'd76, 8'd76, 8'd76, 7'd30);
        add_cfg(lbg_pkg::CFG_LOW, 24'd0);
        add_cfg(lbg_pkg::CFG_HIGH, 24'd100);
        add_cfg(lbg_pkg::CFG_PERIOD, 24'd2);
        add_tick(1'b1);
        add_tick(1'b1);
        add_cfg(lbg_pkg::CFG_PERIOD, 24'd160);       // alternate trough and crest
        add_tick(1'b1);
        add_tick(1'b1);
        add_tick(1'b1);
        add_cfg(lbg_pkg::CFG_PERIOD, 24'hFFFF);
        add_tick(1'b1);
        add_tick(1'b1);
        add_tick(1'b1);
        add_cfg(lbg_pkg::CFG_COLOR, 24'h123456);
        add_cfg(lbg_pkg::CFG_LOW, 24'd5);
        add_cfg(lbg_pkg::CFG_HIGH, 24'd95);
        add_cfg(lbg_pkg::CFG_PERIOD, 24'd1000);
        for (int k = 0; k < 6; k++)
            add_tick(1'b1);
        add_tick(1'b0);
        add_cfg(lbg_pkg::CFG_MODE, {22'd0, lbg_pkg::MODE_SOLID});
        add_cfg(lbg_pkg::CFG_LOW, 24'd0);
        add_cfg(lbg_pkg::CFG_HIGH, 24'd0);
        add_pinned(8'd0, 8'd0, 8'd0, 7'd0);
        add_tick(1'b0);
    endfunction

    // ------------------------------------------------------------------
    // Random settings: breathing most of the time, extremes now and then
    // ------------------------------------------------------------------

    function automatic logic [23:0] rand_pct_data();
        int sel;
        sel = $urandom_range(99);
        if (sel < 10) return 24'd0;
        if (sel < 20) return 24'd100;
        if (sel < 30) return 24'($urandom);          // exercise clamp and masking
        return 24'($urandom_range(100));
    endfunction

    function automatic logic [23:0] rand_period_data();
        int sel;
        sel = $urandom_range(99);
        if (sel < 10) return 24'($urandom_range(3));
        if (sel < 15) return 24'hFFFF;
        if (sel < 25) return 24'($urandom);
        if (sel < 35) return 24'($urandom_range(65535));
        return 24'($urandom_range(4000, 2));
    endfunction

    task automatic pick_setting();
        int         sel;
        logic [1:0] code;
        sel = $urandom_range(99);
        if (sel < 62)      code = lbg_pkg::MODE_BREATHE;
        else if (sel < 80) code = lbg_pkg::MODE_SOLID;
        else if (sel < 92) code = lbg_pkg::MODE_OFF;
        else               code = MODE_UNUSED;
        if ($urandom_range(99) < 80)
            cfg_write(lbg_pkg::CFG_MODE, {22'($urandom), code});
        if ($urandom_range(99) < 70)
            cfg_write(lbg_pkg::CFG_LOW, rand_pct_data());
        if ($urandom_range(99) < 70)
            cfg_write(lbg_pkg::CFG_HIGH, rand_pct_data());
        if ($urandom_range(99) < 70)
            cfg_write(lbg_pkg::CFG_PERIOD, rand_period_data());
        if ($urandom_range(99) < 60)
            cfg_write(lbg_pkg::CFG_COLOR,
                      ($urandom_range(9) == 0) ? 24'hFFFFFF : 24'($urandom));
        if ($urandom_range(99) < 5)
            cfg_write(3'($urandom_range(7, lbg_pkg::CFG_COLOR + 1)), 24'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        int   sent;
        int   burst;
        bit   tick;
        bit   after_ticks;
        t_pin no_pin;
        no_pin = '{on: 1'b0, res: '0};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table; settle before any write that follows tick items
        build_plan();
        after_ticks = 1'b0;
        foreach (plan[n]) begin
            if (plan[n].kind == ROW_CFG) begin
                if (after_ticks)
                    settle();
                after_ticks = 1'b0;
                cfg_write(plan[n].idx, plan[n].data);
            end else begin
                send_tick(plan[n].tick, plan[n].pin);
                after_ticks = 1'b1;
            end
        end

        // random bursts under three idling regimes
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_idle_pct = 18; recv_idle_pct = 75; end
                1: begin send_idle_pct = 75; recv_idle_pct = 18; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            sent = 0;
            while (sent < RANDOM_ITEMS / 3) begin
                settle();
                pick_setting();
                burst = $urandom_range(60, 15);
                for (int k = 0; k < burst; k++) begin
                    tick = ($urandom_range(99) >= 8);
                    send_tick(tick, no_pin);
                    sent++;
                end
            end
        end

        settle();
        if (pending_colors.size() != 0)
            fault_count++;
        if (fault_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
